@@ sv/led_matrix_bitplane_pwm_scanner_defines.svh @@
// Assertion macros shared by the LED matrix bit-plane scanner RTL.
`ifndef LED_MATRIX_BITPLANE_PWM_SCANNER_DEFINES_SVH
`define LED_MATRIX_BITPLANE_PWM_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LMBP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lmbp_pkg.sv @@
// Types, constants and helper functions of the LED matrix bit-plane scanner.
package lmbp_pkg;

    // Sizes
    localparam int MAX_PIXELS      = 1024;
    localparam int MAX_GRAY_LEVELS = 16;
    localparam int CHAN_W          = 8;
    localparam int IDX_W           = $clog2(MAX_PIXELS);
    localparam int PIX_W           = IDX_W + 1;
    localparam int LEVEL_W         = $clog2(MAX_GRAY_LEVELS) + 1;
    localparam int PHASE_W         = 4;
    localparam int LANES           = 8;
    localparam int ROWS            = MAX_PIXELS / LANES;
    localparam int ROW_W           = $clog2(ROWS);
    localparam int ROW_BITS        = LANES * CHAN_W;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = PIX_W;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BRIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRAY_LEVELS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT = 2'd3;

    // Effective configuration seen by the datapath
    typedef struct packed {
        logic [CHAN_W-1:0]  threshold;
        logic [CHAN_W-1:0]  max_brightness;
        logic [LEVEL_W-1:0] levels;
        logic [PIX_W-1:0]   pixels;
    } cfg_t;

    // Command passed from front to back
    typedef struct packed {
        logic              is_shift;
        logic [IDX_W-1:0]  idx;
        logic [CHAN_W-1:0] level;
    } cmd_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic avail;
    } q_stat_t;

    // Exact x / 255 for any x up to 255 * 255
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // Gray levels: zero taken as one, saturated at the maximum
    function automatic logic [LEVEL_W-1:0] eff_levels(input logic [LEVEL_W-1:0] g);
        logic [LEVEL_W-1:0] r;
        r = g;
        if (g == '0)
            r = LEVEL_W'(1);
        else if (g > LEVEL_W'(MAX_GRAY_LEVELS))
            r = LEVEL_W'(MAX_GRAY_LEVELS);
        return r;
    endfunction

    // Pixel count: zero taken as one, saturated at the maximum
    function automatic logic [PIX_W-1:0] eff_pixels(input logic [PIX_W-1:0] p);
        logic [PIX_W-1:0] r;
        r = p;
        if (p == '0)
            r = PIX_W'(1);
        else if (p > PIX_W'(MAX_PIXELS))
            r = PIX_W'(MAX_PIXELS);
        return r;
    endfunction

endpackage

@@ sv/lmbp_if.sv @@
// Valid/ready channel interfaces for pixel commands and output words.
interface lmbp_in_if
    import lmbp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [IDX_W-1:0]  pixel_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] white;

    modport source (output valid, func, pixel_index, red, green, blue, white, input ready);
    modport sink (input valid, func, pixel_index, red, green, blue, white, output ready);
endinterface

interface lmbp_out_if
    import lmbp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  data_byte;
    logic [PHASE_W-1:0] phase;
    logic [ROW_W-1:0]   byte_index;
    logic               last_of_frame;

    modport source (output valid, data_byte, phase, byte_index, last_of_frame, input ready);
    modport sink (input valid, data_byte, phase, byte_index, last_of_frame, output ready);
endinterface

@@ sv/lmbp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lmbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/lmbp_front.sv @@
// Front end: accepts words, scales the strongest channel, drops bad writes.
module lmbp_front
    import lmbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    lmbp_in_if.sink in_ch,
    input  q_stat_t q_stat,
    output logic    push,
    output cmd_t    push_cmd
);

    logic              hold_valid_reg, hold_valid_next;
    logic              hold_shift_reg;
    logic [IDX_W-1:0]  hold_idx_reg;
    logic [15:0]       hold_prod_reg;
    logic [CHAN_W-1:0] chan_max;
    logic [15:0]       prod_next;
    logic              accept;
    logic              drop;
    logic              leave;

    // Strongest channel times max brightness
    always_comb
    begin
        chan_max = in_ch.red;
        if (in_ch.green > chan_max)
            chan_max = in_ch.green;
        if (in_ch.blue > chan_max)
            chan_max = in_ch.blue;
        if (in_ch.white > chan_max)
            chan_max = in_ch.white;
        prod_next = 16'(chan_max) * 16'(cfg.max_brightness);
    end

    // Out-of-range writes leave without a push
    assign drop  = !hold_shift_reg && ({1'b0, hold_idx_reg} >= cfg.pixels);
    assign leave = hold_valid_reg && (drop || !q_stat.full);
    assign push  = hold_valid_reg && !drop && !q_stat.full;

    assign in_ch.ready = !hold_valid_reg || leave;
    assign accept      = in_ch.valid && in_ch.ready;

    assign push_cmd.is_shift = hold_shift_reg;
    assign push_cmd.idx      = hold_idx_reg;
    assign push_cmd.level    = div255(hold_prod_reg);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
            hold_valid_next = 1'b1;
        else if (leave)
            hold_valid_next = 1'b0;
    end

    // Holding stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_shift_reg <= in_ch.func;
            hold_idx_reg   <= in_ch.pixel_index;
            hold_prod_reg  <= prod_next;
        end
    end

endmodule

@@ sv/lmbp_queue.sv @@
// Short command queue between front and back.
module lmbp_queue
    import lmbp_pkg::*;
    `include "led_matrix_bitplane_pwm_scanner_defines.svh"
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.avail = (count_reg != '0);

    `LMBP_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, count_reg != '0, "queue popped while empty")
    `LMBP_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push, count_reg < CNT_W'(DEPTH), "queue overrun")
    `LMBP_ASSERT_IMP(a_q_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count out of range")

endmodule

@@ sv/lmbp_back.sv @@
// Back end: brightness store, PWM slot mask and serial byte builder.
module lmbp_back
    import lmbp_pkg::*;
    `include "led_matrix_bitplane_pwm_scanner_defines.svh"
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       cfg_we,
    input  q_stat_t    q_stat,
    input  cmd_t       q_head,
    output logic       pop,
    lmbp_out_if.source out_ch
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MERGE = 5'b00010,
        ST_MASK  = 5'b00100,
        ST_PIX   = 5'b01000,
        ST_OUT   = 5'b10000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic [ROW_W-1:0]           pos_reg, pos_next;
    logic [PHASE_W-1:0]         step_reg, step_next;
    logic [MAX_GRAY_LEVELS-1:0] mask_reg, mask_next;
    logic                       mask_valid_reg, mask_valid_next;
    logic [LEVEL_W-2:0]         resid_reg [MAX_GRAY_LEVELS];
    logic [LEVEL_W-2:0]         resid_next [MAX_GRAY_LEVELS];
    logic [CHAN_W-1:0]          bits_reg, bits_next;
    logic                       row_ok_reg, row_ok_next;
    logic [ROWS-1:0]            row_valid_reg, row_valid_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [CHAN_W-1:0]          level_reg, level_next;

    logic                       out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]          out_data_reg;
    logic [PHASE_W-1:0]         out_phase_reg;
    logic [ROW_W-1:0]           out_index_reg;
    logic                       out_last_reg;
    logic                       out_free;
    logic                       load_out;
    logic                       last;

    // RAM port
    logic                       ram_we;
    logic                       ram_re;
    logic [ROW_W-1:0]           ram_raddr;
    logic [ROW_BITS-1:0]        ram_wdata;
    logic [ROW_BITS-1:0]        ram_rdata;
    logic [ROW_BITS-1:0]        row_base;

    // Frame geometry and stale phase or position fix-up
    logic [PIX_W:0]             nb_sum;
    logic [ROW_W:0]             nbytes;
    logic [PHASE_W-1:0]         phase_fix;
    logic [ROW_W-1:0]           pos_fix;
    logic [LEVEL_W-1:0]         phase_inc;

    // Pixel evaluation
    logic [2:0]                 lane;
    logic [CHAN_W-1:0]          pix_b;
    logic [PIX_W-1:0]           pix_num;
    logic [12:0]                pix_prod;
    logic [CHAN_W-1:0]          on_raw;
    logic [LEVEL_W-1:0]         on_lv;
    logic [LEVEL_W-1:0]         on_m1;
    logic                       lit;
    logic [LEVEL_W-1:0]         lane_sum [MAX_GRAY_LEVELS];

    lmbp_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[IDX_W-1:3]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign nb_sum    = {1'b0, cfg.pixels} + (PIX_W + 1)'(LANES - 1);
    assign nbytes    = nb_sum[ROW_W+3:3];
    assign phase_fix = ({1'b0, phase_reg} >= cfg.levels) ? '0 : phase_reg;
    assign pos_fix   = ({1'b0, pos_reg} >= nbytes) ? '0 : pos_reg;
    assign last      = ({1'b0, pos_reg} + (ROW_W + 1)'(1)) >= nbytes;
    assign phase_inc = {1'b0, phase_reg} + LEVEL_W'(1);

    assign out_free = !out_valid_reg || out_ch.ready;
    assign load_out = (state_reg == ST_OUT) && out_free;
    assign pop      = (state_reg == ST_IDLE) && q_stat.avail;

    // Row merge for pixel writes; a row never written reads as zero
    always_comb
    begin
        row_base = row_valid_reg[idx_reg[IDX_W-1:3]] ? ram_rdata : '0;
        ram_wdata = row_base;
        ram_wdata[{idx_reg[2:0], 3'b000} +: CHAN_W] = level_reg;
    end

    // Slot accumulators, one lane per on-slot count
    always_comb
    begin
        for (int j = 0; j < MAX_GRAY_LEVELS; j++)
        begin
            lane_sum[j] = {1'b0, resid_reg[j]} + LEVEL_W'(j + 1);
        end
    end

    // One pixel of the current byte
    always_comb
    begin
        lane     = step_reg[2:0];
        pix_b    = row_ok_reg ? ram_rdata[{lane, 3'b000} +: CHAN_W] : '0;
        pix_num  = {1'b0, pos_reg, lane};
        pix_prod = 13'(pix_b) * 13'(cfg.levels);
        on_raw   = div255(16'(pix_prod) + 16'd127);
        on_lv    = (on_raw[LEVEL_W-1:0] == '0) ? LEVEL_W'(1) : on_raw[LEVEL_W-1:0];
        on_m1    = on_lv - LEVEL_W'(1);
        lit      = (pix_num < cfg.pixels)
                   && (pix_b >= cfg.threshold)
                   && ((cfg.levels != LEVEL_W'(1)) || (cfg.threshold != '0))
                   && mask_reg[on_m1[LEVEL_W-2:0]];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        mask_next       = mask_reg;
        mask_valid_next = mask_valid_reg;
        resid_next      = resid_reg;
        bits_next       = bits_reg;
        row_ok_next     = row_ok_reg;
        row_valid_next  = row_valid_reg;
        idx_next        = idx_reg;
        level_next      = level_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = pos_fix;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.avail)
                begin
                    if (q_head.is_shift)
                    begin
                        ram_re      = 1'b1;
                        phase_next  = phase_fix;
                        pos_next    = pos_fix;
                        row_ok_next = row_valid_reg[pos_fix];
                        step_next   = '0;
                        bits_next   = '0;
                        for (int j = 0; j < MAX_GRAY_LEVELS; j++)
                        begin
                            resid_next[j] = '0;
                        end
                        state_next = mask_valid_reg ? ST_PIX : ST_MASK;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = q_head.idx[IDX_W-1:3];
                        idx_next   = q_head.idx;
                        level_next = q_head.level;
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_MERGE:
            begin
                ram_we = 1'b1;
                row_valid_next[idx_reg[IDX_W-1:3]] = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MASK:
            begin
                if (step_reg == phase_reg)
                begin
                    // Lit in this phase when the residue plus the slot count wraps
                    for (int j = 0; j < MAX_GRAY_LEVELS; j++)
                    begin
                        mask_next[j] = (lane_sum[j] >= cfg.levels);
                    end
                    mask_valid_next = 1'b1;
                    step_next       = '0;
                    state_next      = ST_PIX;
                end
                else
                begin
                    for (int j = 0; j < MAX_GRAY_LEVELS; j++)
                    begin
                        if (lane_sum[j] >= cfg.levels)
                            resid_next[j] = (LEVEL_W - 1)'(lane_sum[j] - cfg.levels);
                        else
                            resid_next[j] = lane_sum[j][LEVEL_W-2:0];
                    end
                    step_next = step_reg + PHASE_W'(1);
                end
            end
            ST_PIX:
            begin
                bits_next = {bits_reg[CHAN_W-2:0], lit};
                step_next = step_reg + PHASE_W'(1);
                if (lane == 3'd7)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (last)
                    begin
                        pos_next        = '0;
                        phase_next      = (phase_inc >= cfg.levels) ? '0
                                                                    : phase_inc[PHASE_W-1:0];
                        mask_valid_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_reg + ROW_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Any register write invalidates the slot mask
        if (cfg_we)
            mask_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= '0;
            pos_reg        <= '0;
            step_reg       <= '0;
            mask_valid_reg <= 1'b0;
            row_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            step_reg       <= step_next;
            mask_valid_reg <= mask_valid_next;
            row_valid_reg  <= row_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mask_reg   <= mask_next;
        resid_reg  <= resid_next;
        bits_reg   <= bits_next;
        row_ok_reg <= row_ok_next;
        idx_reg    <= idx_next;
        level_reg  <= level_next;
        if (load_out)
        begin
            out_data_reg  <= bits_reg;
            out_phase_reg <= phase_reg;
            out_index_reg <= pos_reg;
            out_last_reg  <= last;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.data_byte     = out_data_reg;
    assign out_ch.phase         = out_phase_reg;
    assign out_ch.byte_index    = out_index_reg;
    assign out_ch.last_of_frame = out_last_reg;

    `LMBP_ASSERT_IMP(a_pix_mask_ready, clk, rst_n, state_reg == ST_PIX, mask_valid_reg, "pixel step without slot mask")
    `LMBP_ASSERT_NXT(a_frame_wrap, clk, rst_n, load_out && last, pos_reg == '0, "frame end did not rewind position")
    `LMBP_ASSERT_NXT(a_row_marked, clk, rst_n, state_reg == ST_MERGE, row_valid_reg[$past(idx_reg[IDX_W-1:3])], "written row not marked valid")

endmodule

@@ sv/led_matrix_bitplane_pwm_scanner.sv @@
// LED matrix bit-plane PWM scanner: register file, front end, queue and back end.
// A pixel write occupies the back end for a row read and a merge write; a shift word takes
// a row read, 8 pixel steps through one shared scale unit and an output load, plus mask
// steps on the first word of a frame while the slot mask lanes accumulate.
// The back end finishes one command before it pops the next one from the queue.
// Reset: asynchronous, active low; registers return to defaults, phase and position to
// zero, and the per-row valid flags clear at once so the store reads zero; no clear pass.
module led_matrix_bitplane_pwm_scanner
    import lmbp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    lmbp_in_if.sink                in_ch,
    lmbp_out_if.source             out_ch
);

    logic [CHAN_W-1:0]  threshold_reg;
    logic [CHAN_W-1:0]  max_bright_reg;
    logic [LEVEL_W-1:0] gray_levels_reg;
    logic [PIX_W-1:0]   pixel_count_reg;
    cfg_t               cfg;
    logic               push;
    logic               pop;
    cmd_t               push_cmd;
    cmd_t               q_head;
    q_stat_t            q_stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= CHAN_W'(1);
            max_bright_reg  <= CHAN_W'(255);
            gray_levels_reg <= LEVEL_W'(1);
            pixel_count_reg <= PIX_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:   threshold_reg   <= cfg_wdata[CHAN_W-1:0];
                CFG_MAX_BRIGHT:  max_bright_reg  <= cfg_wdata[CHAN_W-1:0];
                CFG_GRAY_LEVELS: gray_levels_reg <= cfg_wdata[LEVEL_W-1:0];
                CFG_PIXEL_COUNT: pixel_count_reg <= cfg_wdata[PIX_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.threshold      = threshold_reg;
    assign cfg.max_brightness = max_bright_reg;
    assign cfg.levels         = eff_levels(gray_levels_reg);
    assign cfg.pixels         = eff_pixels(pixel_count_reg);

    lmbp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_ch    (in_ch),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lmbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    lmbp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cfg_we (cfg_we),
        .q_stat (q_stat),
        .q_head (q_head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the LED matrix bit-plane PWM scanner.
`timescale 1ns / 100ps

module tb;
    import lmbp_pkg::*;

    localparam logic FUNC_WRITE    = 1'b0;
    localparam logic FUNC_SHIFT    = 1'b1;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   STALL_LIMIT   = 5000;

    // One input word and one output word
    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  pixel_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] white;
    } pixel_cmd_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  data_byte;
        logic [PHASE_W-1:0] phase;
        logic [ROW_W-1:0]   byte_index;
        logic               last_of_frame;
    } scan_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    lmbp_in_if  cmd_ch ();
    lmbp_out_if word_ch ();

    led_matrix_bitplane_pwm_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (cmd_ch),
        .out_ch    (word_ch)
    );

    // Shadow of the scanner state and its registers
    logic [CHAN_W-1:0] shadow_level [MAX_PIXELS];
    int unsigned       scan_phase;
    int unsigned       scan_pos;
    logic [7:0]        thr_reg;
    logic [7:0]        bright_reg;
    logic [4:0]        levels_reg;
    logic [10:0]       pixels_reg;

    pixel_cmd_t  cmd_backlog [$];
    scan_word_t  bytes_due [$];
    pixel_cmd_t  next_cmd;
    pixel_cmd_t  seen_cmd;
    scan_word_t  want_word;
    scan_word_t  got_word;
    int unsigned cmds_queued;
    int unsigned cmds_accepted;
    int unsigned err_count;
    int unsigned quiet_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          cmd_fired;
    bit          word_fired;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned live_levels();
        int unsigned g;
        g = levels_reg;
        if (g == 0)
            g = 1;
        if (g > MAX_GRAY_LEVELS)
            g = MAX_GRAY_LEVELS;
        return g;
    endfunction

    function automatic int unsigned live_pixels();
        int unsigned p;
        p = pixels_reg;
        if (p == 0)
            p = 1;
        if (p > MAX_PIXELS)
            p = MAX_PIXELS;
        return p;
    endfunction

    // Lit when over threshold and the phase falls in the spread on-slots
    function automatic bit pixel_on(input logic [7:0] lvl, input int unsigned ph,
                                    input int unsigned g);
        int unsigned slot_count;
        if (g == 1)
            return (thr_reg != 0) && (lvl >= thr_reg);
        if (lvl < thr_reg)
            return 1'b0;
        slot_count = (32'(lvl) * g + 127) / 255;
        if (slot_count == 0)
            slot_count = 1;
        return ((ph * slot_count) / g) != (((ph + 1) * slot_count) / g);
    endfunction

    // Apply one accepted word to the shadow; shifts queue the byte they yield
    task automatic scan_step(input pixel_cmd_t c);
        int unsigned g;
        int unsigned p;
        int unsigned nbytes;
        int unsigned px;
        int unsigned peak;
        scan_word_t  w;
        g = live_levels();
        p = live_pixels();
        if (c.func == FUNC_WRITE)
        begin
            peak = c.red;
            if (c.green > peak)
                peak = c.green;
            if (c.blue > peak)
                peak = c.blue;
            if (c.white > peak)
                peak = c.white;
            if (c.pixel_index < p)
                shadow_level[c.pixel_index] = 8'((peak * bright_reg) / 255);
        end
        else
        begin
            nbytes = (p + 7) / 8;
            // stale phase or position after a register change restarts at zero
            if (scan_phase >= g)
                scan_phase = 0;
            if (scan_pos >= nbytes)
                scan_pos = 0;
            w = '0;
            for (int i = 0; i < 8; i++)
            begin
                px = scan_pos * 8 + i;
                if (px < p && pixel_on(shadow_level[px], scan_phase, g))
                    w.data_byte[7-i] = 1'b1;
            end
            w.phase         = PHASE_W'(scan_phase);
            w.byte_index    = ROW_W'(scan_pos);
            w.last_of_frame = (scan_pos + 1 >= nbytes);
            bytes_due.push_back(w);
            if (w.last_of_frame)
            begin
                scan_pos = 0;
                scan_phase++;
                if (scan_phase >= g)
                    scan_phase = 0;
            end
            else
            begin
                scan_pos++;
            end
        end
    endtask

    // Driver: next word at the falling edge once the current one is taken
    always @(negedge clk)
    begin
        if (!cmd_ch.valid || cmd_fired)
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_cmd = cmd_backlog.pop_front();
                cmd_ch.valid       <= 1'b1;
                cmd_ch.func        <= next_cmd.func;
                cmd_ch.pixel_index <= next_cmd.pixel_index;
                cmd_ch.red         <= next_cmd.red;
                cmd_ch.green       <= next_cmd.green;
                cmd_ch.blue        <= next_cmd.blue;
                cmd_ch.white       <= next_cmd.white;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
        word_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: accepted words at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cmd_fired  = cmd_ch.valid && cmd_ch.ready;
            word_fired = word_ch.valid && word_ch.ready;
            if (cmd_fired)
            begin
                seen_cmd.func        = cmd_ch.func;
                seen_cmd.pixel_index = cmd_ch.pixel_index;
                seen_cmd.red         = cmd_ch.red;
                seen_cmd.green       = cmd_ch.green;
                seen_cmd.blue        = cmd_ch.blue;
                seen_cmd.white       = cmd_ch.white;
                scan_step(seen_cmd);
                cmds_accepted++;
            end
            if (word_fired)
            begin
                got_word.data_byte     = word_ch.data_byte;
                got_word.phase         = word_ch.phase;
                got_word.byte_index    = word_ch.byte_index;
                got_word.last_of_frame = word_ch.last_of_frame;
                if (bytes_due.size() == 0)
                begin
                    $error("unexpected output word %h", got_word);
                    err_count++;
                end
                else
                begin
                    want_word = bytes_due.pop_front();
                    if (got_word.data_byte !== want_word.data_byte)
                    begin
                        $error("data_byte: expected %h, got %h",
                               want_word.data_byte, got_word.data_byte);
                        err_count++;
                    end
                    if (got_word.phase !== want_word.phase)
                    begin
                        $error("phase: expected %0d, got %0d",
                               want_word.phase, got_word.phase);
                        err_count++;
                    end
                    if (got_word.byte_index !== want_word.byte_index)
                    begin
                        $error("byte_index: expected %0d, got %0d",
                               want_word.byte_index, got_word.byte_index);
                        err_count++;
                    end
                    if (got_word.last_of_frame !== want_word.last_of_frame)
                    begin
                        $error("last_of_frame: expected %0b, got %0b",
                               want_word.last_of_frame, got_word.last_of_frame);
                        err_count++;
                    end
                end
            end
            quiet_cycles = (cmd_fired || word_fired) ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog on cycles with no traffic
    always @(negedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[led_matrix_bitplane_pwm_scanner] ERROR");
            $finish;
        end
    end

    // Channel value biased toward the extremes
    function automatic int unsigned rand_chan();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic queue_write(input int unsigned idx, input int unsigned r,
                               input int unsigned g, input int unsigned b,
                               input int unsigned w);
        pixel_cmd_t c;
        c.func        = FUNC_WRITE;
        c.pixel_index = IDX_W'(idx);
        c.red         = CHAN_W'(r);
        c.green       = CHAN_W'(g);
        c.blue        = CHAN_W'(b);
        c.white       = CHAN_W'(w);
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    // Shift request; the unused fields carry noise
    task automatic queue_shift();
        pixel_cmd_t c;
        c.func        = FUNC_SHIFT;
        c.pixel_index = IDX_W'($urandom_range(0, MAX_PIXELS - 1));
        c.red         = CHAN_W'($urandom_range(0, 255));
        c.green       = CHAN_W'($urandom_range(0, 255));
        c.blue        = CHAN_W'($urandom_range(0, 255));
        c.white       = CHAN_W'($urandom_range(0, 255));
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    // Wait until every word is taken and every byte is back, then let the back end settle
    task automatic wait_idle();
        while (cmds_accepted != cmds_queued || bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_THRESHOLD:   thr_reg    = 8'(value);
            CFG_MAX_BRIGHT:  bright_reg = 8'(value);
            CFG_GRAY_LEVELS: levels_reg = 5'(value);
            CFG_PIXEL_COUNT: pixels_reg = 11'(value);
            default: ;
        endcase
    endtask

    // New settings, then a random mix of pixel writes and frame shifts
    task automatic run_phase(input int unsigned thr, input int unsigned mb,
                             input int unsigned gl, input int unsigned pc,
                             input int unsigned n_items, input int unsigned send_pct,
                             input int unsigned recv_pct);
        int unsigned p;
        int unsigned pick;
        wait_idle();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_MAX_BRIGHT, mb);
        write_reg(CFG_GRAY_LEVELS, gl);
        write_reg(CFG_PIXEL_COUNT, pc);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        p = live_pixels();
        repeat (n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                queue_write($urandom_range(0, p - 1), rand_chan(), rand_chan(),
                            rand_chan(), rand_chan());
            else if (pick < 36)
                queue_write($urandom_range(0, MAX_PIXELS - 1), rand_chan(), rand_chan(),
                            rand_chan(), rand_chan());
            else
                queue_shift();
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_wdata           = '0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.func         = FUNC_WRITE;
        cmd_ch.pixel_index  = '0;
        cmd_ch.red          = '0;
        cmd_ch.green        = '0;
        cmd_ch.blue         = '0;
        cmd_ch.white        = '0;
        word_ch.ready       = 1'b0;
        cmds_queued         = 0;
        cmds_accepted       = 0;
        err_count           = 0;
        quiet_cycles        = 0;
        cmd_fired           = 1'b0;
        word_fired          = 1'b0;
        send_idle_pct       = 25;
        recv_idle_pct       = 86;
        for (int i = 0; i < MAX_PIXELS; i++)
            shadow_level[i] = '0;
        scan_phase = 0;
        scan_pos   = 0;
        thr_reg    = 8'd1;
        bright_reg = 8'd255;
        levels_reg = 5'd1;
        pixels_reg = 11'd64;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, single-threshold mode, 64 pixels
        queue_write(0, 255, 0, 0, 0);
        queue_write(63, 0, 0, 0, 1);
        queue_write(7, 0, 128, 200, 0);
        queue_write(64, 255, 0, 0, 0);      // just past the chain: ignored
        queue_write(1023, 255, 255, 255, 255);
        queue_write(9, 170, 85, 0, 0);
        queue_write(10, 85, 170, 85, 170);
        queue_write(8, 0, 0, 0, 0);
        repeat (8) queue_shift();
        // threshold 0 in single-threshold mode lights nothing
        wait_idle();
        write_reg(CFG_THRESHOLD, 0);
        repeat (4) queue_shift();

        // Random phases: sender/receiver idling, then swapped, then none
        run_phase(0, 255, 4, 64, 90, 25, 86);
        run_phase(128, 100, 16, 20, 90, 25, 86);
        run_phase(255, 255, 3, 1, 60, 25, 86);
        run_phase(1, 0, 2, 9, 70, 25, 86);
        run_phase(10, 255, 0, 0, 60, 86, 25);
        run_phase(50, 200, 31, 2047, 110, 86, 25);
        run_phase(0, 255, 1, 16, 80, 86, 25);
        run_phase(200, 255, 16, 8, 100, 0, 0);
        run_phase(1, 128, 5, 33, 90, 0, 0);
        run_phase(64, 255, 7, 1000, 100, 0, 0);

        wait_idle();
        if (err_count == 0 && bytes_due.size() == 0)
            $display("[led_matrix_bitplane_pwm_scanner] OK");
        else
            $display("[led_matrix_bitplane_pwm_scanner] ERROR");
        $finish;
    end

endmodule
